/* design/pida_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pida_pkg;

  localparam int unsigned REQ_W  = 3;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LEN_W  = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT   = 3'd0,
    REQ_APPEND   = 3'd1,
    REQ_MODIFY   = 3'd2,
    REQ_DELETE   = 3'd3,
    REQ_DEL_LAST = 3'd4,
    REQ_REMOVE   = 3'd5,
    REQ_READ     = 3'd6
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_BAD  = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  typedef enum logic [2:0] {
    CM_HOLD   = 3'd0,
    CM_INSERT = 3'd1,
    CM_WRITE  = 3'd2,
    CM_DELETE = 3'd3,
    CM_SCAN   = 3'd4
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e mode;
    logic       keep;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* design/pida_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module pida_cell
  import pida_pkg::*;
#(
  parameter int unsigned ELEM_WIDTH = 32,
  parameter int unsigned IDX_W      = 4,
  parameter int unsigned INDEX      = 0
) (
  input  wire logic                  clk_i,
  input  wire cell_ctl_t             ctl_i,
  input  wire logic [IDX_W-1:0]      sel_i,
  input  wire logic [ELEM_WIDTH-1:0] left_i,
  input  wire logic [ELEM_WIDTH-1:0] right_i,
  input  wire logic [ELEM_WIDTH-1:0] head_i,
  input  wire logic [ELEM_WIDTH-1:0] value_i,
  output logic      [ELEM_WIDTH-1:0] elem_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [ELEM_WIDTH-1:0] elem_q, elem_d;

  always_comb begin
    elem_d = elem_q;
    case (ctl_i.mode)
      CM_INSERT: begin
        if (MyIdx > sel_i) begin
          elem_d = left_i;
        end else if (MyIdx == sel_i) begin
          elem_d = value_i;
        end
      end
      CM_WRITE: begin
        if (MyIdx == sel_i) begin
          elem_d = value_i;
        end
      end
      CM_DELETE: begin
        if (MyIdx >= sel_i) begin
          elem_d = right_i;
        end
      end
      CM_SCAN: begin
        // rotate down; a kept head re-enters at the tail of the live region
        if (ctl_i.keep && (MyIdx == sel_i)) begin
          elem_d = head_i;
        end else begin
          elem_d = right_i;
        end
      end
      default: elem_d = elem_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
  end

  assign elem_o = elem_q;

endmodule

`default_nettype wire

/* design/pida_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module pida_ctrl
  import pida_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ELEM_WIDTH = 32,
  parameter int unsigned IDX_W      = 4,
  parameter int unsigned CNT_W      = 5
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [REQ_W-1:0]      req_type_i,
  input  wire logic [POS_W-1:0]      position_i,
  input  wire logic [VAL_W-1:0]      value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic      [STAT_W-1:0]     status_o,
  output logic      [VAL_W-1:0]      read_value_o,
  output logic      [LEN_W-1:0]      length_now_o,
  output logic      [LEN_W-1:0]      removed_count_o,
  input  wire logic [ELEM_WIDTH-1:0] head_i,
  input  wire logic [ELEM_WIDTH-1:0] rd_elem_i,
  output cell_ctl_t                  ctl_o,
  output logic      [IDX_W-1:0]      sel_o,
  output logic      [ELEM_WIDTH-1:0] wval_o
);

  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] Full = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] One  = CNT_W'(1);

  state_e state_q, state_d;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] left_q, left_d;   // elements still to examine
  logic [CNT_W-1:0] kept_q, kept_d;   // live region length during scan
  logic [ELEM_WIDTH-1:0] match_q, match_d;

  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [VAL_W-1:0]  rdval_q, rdval_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  rem_q, rem_d;

  logic                 accept;
  logic                 load_out;
  logic [CMP_W-1:0]     pos_x, cnt_x;
  logic [IDX_W-1:0]     pos_idx;
  logic [63:0]          val64;
  logic signed [63:0]   rd64;
  req_e                 req;

  assign req       = req_e'(req_type_i);
  assign pos_x     = CMP_W'(position_i);
  assign cnt_x     = CMP_W'(cnt_q);
  assign pos_idx   = pos_x[IDX_W-1:0];
  assign val64     = {32'd0, value_i};
  assign wval_o    = val64[ELEM_WIDTH-1:0];
  assign rd64      = 64'(signed'(rd_elem_i));

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (req == REQ_REMOVE)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (left_q == '0) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o.mode = CM_HOLD;
    ctl_o.keep = 1'b0;
    sel_o      = pos_idx;
    cnt_d      = cnt_q;
    left_d     = left_q;
    kept_d     = kept_q;
    match_d    = match_q;
    load_out   = 1'b0;
    status_d   = STAT_OK;
    rdval_d    = '0;
    rem_d      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (req == REQ_APPEND) begin
          sel_o = cnt_q[IDX_W-1:0];
        end
        if (accept) begin
          load_out = 1'b1;
          case (req)
            REQ_INSERT: begin
              if (pos_x > cnt_x) begin
                status_d = STAT_BAD;
              end else if (cnt_q == Full) begin
                status_d = STAT_FULL;
              end else begin
                ctl_o.mode = CM_INSERT;
                cnt_d      = cnt_q + One;
              end
            end
            REQ_APPEND: begin
              if (cnt_q == Full) begin
                status_d = STAT_FULL;
              end else begin
                ctl_o.mode = CM_INSERT;
                cnt_d      = cnt_q + One;
              end
            end
            REQ_MODIFY: begin
              if (pos_x >= cnt_x) begin
                status_d = STAT_BAD;
              end else begin
                ctl_o.mode = CM_WRITE;
              end
            end
            REQ_DELETE: begin
              if (pos_x >= cnt_x) begin
                status_d = STAT_BAD;
              end else begin
                ctl_o.mode = CM_DELETE;
                cnt_d      = cnt_q - One;
                rem_d      = LEN_W'(1);
              end
            end
            REQ_DEL_LAST: begin
              if (cnt_q == '0) begin
                status_d = STAT_BAD;
              end else begin
                cnt_d = cnt_q - One;
                rem_d = LEN_W'(1);
              end
            end
            REQ_REMOVE: begin
              load_out = 1'b0;
              left_d   = cnt_q;
              kept_d   = cnt_q;
              match_d  = wval_o;
            end
            REQ_READ: begin
              if (pos_x >= cnt_x) begin
                status_d = STAT_BAD;
              end else begin
                rdval_d = rd64[VAL_W-1:0];
              end
            end
            default: status_d = STAT_BAD;
          endcase
        end
      end
      ST_SCAN: begin
        sel_o = IDX_W'(kept_q - One);
        if (left_q == '0) begin
          load_out = 1'b1;
          cnt_d    = kept_q;
          rem_d    = LEN_W'(cnt_q - kept_q);
        end else begin
          ctl_o.mode = CM_SCAN;
          ctl_o.keep = (head_i != match_q);
          left_d     = left_q - One;
          if (head_i == match_q) begin
            kept_d = kept_q - One;
          end
        end
      end
      default: begin
        ctl_o.mode = CM_HOLD;
      end
    endcase
  end

  assign len_d       = LEN_W'(cnt_d);
  assign out_valid_d = load_out || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      left_q      <= '0;
      kept_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      left_q      <= left_d;
      kept_q      <= kept_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_q <= match_d;
    if (load_out) begin
      status_q <= status_d;
      rdval_q  <= rdval_d;
      len_q    <= len_d;
      rem_q    <= rem_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign read_value_o    = rdval_q;
  assign length_now_o    = len_q;
  assign removed_count_o = rem_q;

endmodule

`default_nettype wire

/* design/positional_insert_delete_array.sv */
// Timing: the result of an accepted beat is registered and offered in the next cycle for every request
// except remove-all-equal, which first rotates every stored element through cell 0, one element a cycle.
// Throughput: one beat per cycle while results are taken; input stalls during a scan.
// Reset: asynchronous, active low; clears element count, control and output valid.
// Element cells are not reset.
`timescale 1ns / 1ps
`default_nettype none

module positional_insert_delete_array
  import pida_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [REQ_W-1:0]  req_type_i,
  input  wire logic [POS_W-1:0]  position_i,
  input  wire logic [VAL_W-1:0]  value_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [STAT_W-1:0] status_o,
  output logic      [VAL_W-1:0]  read_value_o,
  output logic      [LEN_W-1:0]  length_now_o,
  output logic      [LEN_W-1:0]  removed_count_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [ELEM_WIDTH-1:0] elem [DEPTH];
  logic [ELEM_WIDTH-1:0] wval;
  logic [ELEM_WIDTH-1:0] rd_elem;
  logic [IDX_W-1:0]      sel;
  cell_ctl_t             ctl;

  assign rd_elem = elem[sel];

  pida_ctrl #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .position_i      (position_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .read_value_o    (read_value_o),
    .length_now_o    (length_now_o),
    .removed_count_o (removed_count_o),
    .head_i          (elem[0]),
    .rd_elem_i       (rd_elem),
    .ctl_o           (ctl),
    .sel_o           (sel),
    .wval_o          (wval)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    pida_cell #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .IDX_W      (IDX_W),
      .INDEX      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .sel_i   (sel),
      .left_i  (elem[(i == 0) ? 0 : i - 1]),
      .right_i (elem[(i == DEPTH - 1) ? DEPTH - 1 : i + 1]),
      .head_i  (elem[0]),
      .value_i (wval),
      .elem_o  (elem[i])
    );
  end

endmodule

`default_nettype wire

/* design/pida_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module pida_checker
  import pida_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic [REQ_W-1:0]  req_type_i,
  input wire logic [POS_W-1:0]  position_i,
  input wire logic [VAL_W-1:0]  value_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [STAT_W-1:0] status_o,
  input wire logic [VAL_W-1:0]  read_value_o,
  input wire logic [LEN_W-1:0]  length_now_o,
  input wire logic [LEN_W-1:0]  removed_count_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(req_type_i)
      && $stable(position_i) && $stable(value_i))
    else $error("request beat changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(read_value_o) && $stable(length_now_o) && $stable(removed_count_o))
    else $error("result beat changed while stalled");

  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_FULL) |-> length_now_o == LEN_W'(DEPTH))
    else $error("full status with array not full");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_OK) |-> (removed_count_o == '0) && (read_value_o == '0))
    else $error("failed request reports data");

  a_rem_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (removed_count_o != '0) |-> (status_o == STAT_OK) && (read_value_o == '0))
    else $error("removal with bad status or read data");

endmodule

bind positional_insert_delete_array pida_checker #(.DEPTH(DEPTH)) u_pida_checker (.*);

`default_nettype wire

/* tb/tb_positional_insert_delete_array.sv */
`timescale 1ns / 1ps

module tb_positional_insert_delete_array;
  import pida_pkg::*;

  localparam int DEPTH = 16;
  localparam int STALL_LIMIT = 1000;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  rd;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  removed;
  } outcome_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [REQ_W-1:0]  req_type_i = '0;
  logic [POS_W-1:0]  position_i = '0;
  logic [VAL_W-1:0]  value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [STAT_W-1:0] status_o;
  logic [VAL_W-1:0]  read_value_o;
  logic [LEN_W-1:0]  length_now_o;
  logic [LEN_W-1:0]  removed_count_o;

  logic [VAL_W-1:0] shadow_elems [DEPTH];
  int               shadow_len = 0;
  outcome_t         pending_outcomes [$];
  int               mismatches = 0;
  int               stall_cycles = 0;
  bit               tx_idle_on = 1'b1;
  bit               rx_idle_on = 1'b1;
  int               hold_len = 0;

  positional_insert_delete_array #(
    .DEPTH     (DEPTH),
    .ELEM_WIDTH(32)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .position_i     (position_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .read_value_o   (read_value_o),
    .length_now_o   (length_now_o),
    .removed_count_o(removed_count_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic outcome_t apply_req(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
                                         logic [VAL_W-1:0] val);
    outcome_t o;
    int       w;
    o.status  = STAT_OK;
    o.rd      = '0;
    o.removed = '0;
    case (req)
      REQ_INSERT, REQ_APPEND: begin
        if (req == REQ_INSERT && int'(pos) > shadow_len) begin
          o.status = STAT_BAD;
        end else if (shadow_len >= DEPTH) begin
          o.status = STAT_FULL;
        end else begin
          if (req == REQ_APPEND) pos = POS_W'(shadow_len);
          for (int i = shadow_len; i > int'(pos); i--) shadow_elems[i] = shadow_elems[i-1];
          shadow_elems[pos] = val;
          shadow_len++;
        end
      end
      REQ_MODIFY: begin
        if (int'(pos) >= shadow_len) o.status = STAT_BAD;
        else shadow_elems[pos] = val;
      end
      REQ_DELETE: begin
        if (int'(pos) >= shadow_len) begin
          o.status = STAT_BAD;
        end else begin
          for (int i = int'(pos); i + 1 < shadow_len; i++) shadow_elems[i] = shadow_elems[i+1];
          shadow_len--;
          o.removed = LEN_W'(1);
        end
      end
      REQ_DEL_LAST: begin
        if (shadow_len == 0) begin
          o.status = STAT_BAD;
        end else begin
          shadow_len--;
          o.removed = LEN_W'(1);
        end
      end
      REQ_REMOVE: begin
        w = 0;
        for (int i = 0; i < shadow_len; i++) begin
          if (shadow_elems[i] == val) begin
            o.removed++;
          end else begin
            shadow_elems[w] = shadow_elems[i];
            w++;
          end
        end
        shadow_len = w;
      end
      REQ_READ: begin
        if (int'(pos) >= shadow_len) o.status = STAT_BAD;
        else o.rd = shadow_elems[pos];
      end
      default: o.status = STAT_BAD;
    endcase
    o.len = LEN_W'(shadow_len);
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  task automatic send_req(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
                          logic [VAL_W-1:0] val);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    position_i <= pos;
    value_i    <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_outcomes.push_back(apply_req(req, pos, val));
  endtask

  // receiving side: random bursts of back-pressure, plus the long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
        out_ready_i <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    outcome_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat status=%0d len=%0d",
                                  status_o, length_now_o));
      end else begin
        want = pending_outcomes.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status got %0d exp %0d", status_o, want.status));
        if (read_value_o !== want.rd)
          report_mismatch($sformatf("read_value got %h exp %h", read_value_o, want.rd));
        if (length_now_o !== want.len)
          report_mismatch($sformatf("length_now got %0d exp %0d", length_now_o, want.len));
        if (removed_count_o !== want.removed)
          report_mismatch($sformatf("removed_count got %0d exp %0d",
                                    removed_count_o, want.removed));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return VAL_W'($urandom_range(0, 7));
    if (r < 65) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'hFFFF_FFFF;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [REQ_W-1:0] pick_req(bit grow);
    int r;
    r = $urandom_range(0, 99);
    if (grow) begin
      if (r < 30) return REQ_INSERT;
      if (r < 55) return REQ_APPEND;
      if (r < 65) return REQ_MODIFY;
      if (r < 73) return REQ_DELETE;
      if (r < 78) return REQ_DEL_LAST;
      if (r < 85) return REQ_REMOVE;
      return REQ_READ;
    end
    if (r < 8) return REQ_INSERT;
    if (r < 15) return REQ_APPEND;
    if (r < 25) return REQ_MODIFY;
    if (r < 50) return REQ_DELETE;
    if (r < 65) return REQ_DEL_LAST;
    if (r < 80) return REQ_REMOVE;
    return REQ_READ;
  endfunction

  task automatic send_random_req(bit grow);
    logic [REQ_W-1:0] req;
    logic [POS_W-1:0] pos;
    req = pick_req(grow);
    if ($urandom_range(0, 4) == 0) pos = POS_W'($urandom_range(0, DEPTH));
    else if (req == REQ_INSERT) pos = POS_W'($urandom_range(0, shadow_len));
    else if (shadow_len > 0) pos = POS_W'($urandom_range(0, shadow_len - 1));
    else pos = '0;
    send_req(req, pos, pick_value());
  endtask

  task automatic test_directed();
    send_req(REQ_READ, 0, '0);
    send_req(REQ_DELETE, 0, '0);
    send_req(REQ_DEL_LAST, 0, '0);
    send_req(REQ_REMOVE, 0, '0);
    send_req(REQ_MODIFY, 0, 32'h1);
    send_req(REQ_INSERT, 1, 32'h5);
    send_req(REQ_UNUSED, 0, '0);
    send_req(REQ_INSERT, 0, 32'h8000_0000);
    send_req(REQ_APPEND, 0, 32'h7FFF_FFFF);
    send_req(REQ_INSERT, 1, '0);
    send_req(REQ_INSERT, 3, 32'hFFFF_FFFF);
    repeat (12) send_req(REQ_APPEND, POS_W'($urandom_range(0, DEPTH)), 32'h5A5A);
    send_req(REQ_APPEND, 0, 32'h1);
    send_req(REQ_INSERT, POS_W'(DEPTH), 32'h1);
    send_req(REQ_READ, POS_W'(DEPTH), '0);
    send_req(REQ_READ, POS_W'(DEPTH - 1), '0);
    send_req(REQ_MODIFY, POS_W'(DEPTH - 1), 32'h5A5A);
    send_req(REQ_DELETE, POS_W'(DEPTH), '0);
    send_req(REQ_REMOVE, 0, 32'h5A5A);
    send_req(REQ_READ, 1, '0);
    send_req(REQ_DELETE, 1, '0);
    send_req(REQ_DEL_LAST, 0, '0);
    send_req(REQ_DEL_LAST, 0, '0);
  endtask

  task automatic test_random_mix(int n);
    bit grow;
    grow = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) begin
        grow       = ~grow;
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on = $urandom_range(0, 3) != 0;
      end
      send_random_req(grow);
    end
  endtask

  // receiver holds off long enough for the output side to fill and stall input beats
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    hold_len   = 90;
    repeat (24) send_random_req(1'b1);
  endtask

  task automatic test_back_to_back(int n);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int i = 0; i < n; i++) send_random_req(i % 40 < 20);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_mix(360);
    test_backpressure();
    test_back_to_back(80);
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (2 * DEPTH + 4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
